// File: hw/rtl/tsd_pkg.sv
// Shared types, codes and constants for the task slot dispatcher.
package tsd_pkg;

	localparam int SlotsDefault = 16;
	localparam int CntW         = 5;   // slot counts and scan positions
	localparam int MaskW        = 16;
	localparam int MaxReap      = 16;
	localparam int IdW          = 32;

	// operations
	localparam logic [2:0] OP_SUBMIT = 3'd0;
	localparam logic [2:0] OP_FINISH = 3'd1;
	localparam logic [2:0] OP_REAP   = 3'd2;
	localparam logic [2:0] OP_QUERY  = 3'd3;
	localparam logic [2:0] OP_COUNT  = 3'd4;

	// result status
	localparam logic [2:0] STS_DISPATCHED = 3'd0;
	localparam logic [2:0] STS_INLINE     = 3'd1;
	localparam logic [2:0] STS_BUSY       = 3'd2;
	localparam logic [2:0] STS_REAPED     = 3'd3;
	localparam logic [2:0] STS_NONE       = 3'd4;
	localparam logic [2:0] STS_ANSWER     = 3'd5;

	// slot states
	localparam logic [1:0] SL_FREE      = 2'd0;
	localparam logic [1:0] SL_SUBMITTED = 2'd1;
	localparam logic [1:0] SL_DONE      = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_ACTIVE = 2'd0;
	localparam logic [1:0] CFG_INLINE = 2'd1;
	localparam logic [1:0] CFG_MASK   = 2'd2;

	typedef struct packed {
		logic [2:0]     operation;
		logic [3:0]     slot;
		logic [IdW-1:0] query_id;
	} req_t;

	typedef struct packed {
		logic [2:0]      status;
		logic [IdW-1:0]  task_id;
		logic [3:0]      slot_index;
		logic            is_done;
		logic [CntW-1:0] free_count;
		logic            last;
	} rsp_t;

	// commands from the sequencer to the slot table
	typedef struct packed {
		logic       finish;  // submitted -> done, if submitted
		logic       st_we;
		logic [1:0] st_val;
		logic       id_we;
		logic       rd_en;
	} tbl_cmd_t;

	function automatic rsp_t mk_rsp(logic [2:0] status, logic [IdW-1:0] id,
			logic [3:0] idx, logic done, logic [CntW-1:0] cnt, logic last);
		rsp_t r;
		r.status     = status;
		r.task_id    = id;
		r.slot_index = idx;
		r.is_done    = done;
		r.free_count = cnt;
		r.last       = last;
		return r;
	endfunction

endpackage

// File: hw/rtl/tsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tsd_ram #(
	parameter int Width = 32,
	parameter int Depth = 16,
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [Width-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];
	logic [Width-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// File: hw/rtl/tsd_slot_table.sv
// Slot state flops and the task id memory.
module tsd_slot_table import tsd_pkg::*; #(
	parameter int Slots = SlotsDefault,
	localparam int AW = (Slots > 1) ? $clog2(Slots) : 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [AW-1:0]  idx,
	input  tbl_cmd_t       cmd,
	input  logic [IdW-1:0] wdata,
	output logic [1:0]     st,
	output logic [IdW-1:0] rdata
);
	logic [1:0]     st_q  [Slots];
	logic [Slots-1:0] written_q;
	logic           rd_written_q;
	logic [IdW-1:0] ram_rdata;

	assign st = st_q[idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < Slots; s++) begin
				st_q[s] <= SL_FREE;
			end
			written_q    <= '0;
			rd_written_q <= 1'b0;
		end else begin
			if (cmd.st_we) begin
				st_q[idx] <= cmd.st_val;
			end else if (cmd.finish && st_q[idx] == SL_SUBMITTED) begin
				st_q[idx] <= SL_DONE;
			end
			if (cmd.id_we) begin
				written_q[idx] <= 1'b1;
			end
			if (cmd.rd_en) begin
				rd_written_q <= written_q[idx];
			end
		end
	end

	tsd_ram #(
		.Width(IdW),
		.Depth(Slots)
	) u_id_ram (
		.clk  (clk),
		.we   (cmd.id_we),
		.waddr(idx),
		.wdata(wdata),
		.re   (cmd.rd_en),
		.raddr(idx),
		.rdata(ram_rdata)
	);

	// an id never written reads as zero
	assign rdata = rd_written_q ? ram_rdata : '0;
endmodule

// File: hw/rtl/task_slot_dispatcher.sv
// Top level: request sequencer, configuration registers and result register.
//
// Each request is handled by a small sequencer that walks the active slots one at a
// time through a shared slot table and a single-port-read id memory, so the block
// takes one request at a time. Worker-finished and unknown operations are handled in
// the idle state and give no result; inline requests and id-zero queries skip the scan.
// Submit stops at the first usable free slot, or reports busy when none of the n
// active slots is, where n is the effective number of active slots; count-free scans
// all n. Query-done examines each slot in a scan and a compare state, because each
// compare waits on the registered id memory read. Reap reads the id of each reaped
// slot, and at most 16 slots are reaped per request. A finished result waits in an
// output register, so a stalled consumer only holds up the next result.
module task_slot_dispatcher import tsd_pkg::*; #(
	parameter int Slots = SlotsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  req_t        req,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output rsp_t        rsp,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [MaskW-1:0] cfg_data
);
	localparam int AW = (Slots > 1) ? $clog2(Slots) : 1;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_CMP   = 3'd2;
	localparam logic [2:0] S_RDATA = 3'd3;
	localparam logic [2:0] S_PUT   = 3'd4;

	logic [2:0]      state_q, ret_q;
	logic [2:0]      op_q;
	logic [CntW-1:0] i_q, k_q, cnt_q;
	logic            held_v_q, out_v_q;
	logic [IdW-1:0]  next_id_q;
	logic [CntW-1:0] active_q;
	logic            inline_q;
	logic [MaskW-1:0] mask_q;

	logic [IdW-1:0]  id_q, qid_q, held_id_q;
	logic [3:0]      held_slot_q;
	rsp_t            res_q, out_q;

	tbl_cmd_t        cmd;
	logic [AW-1:0]   idx, scan_idx, fin_idx;
	logic [1:0]      st;
	logic [IdW-1:0]  rdata;
	logic [CntW-1:0] n;
	logic            at_end, usable, free_ok, fin_ok, accept;
	logic [IdW-1:0]  sub_id, sub_next;
	logic [CntW+AW-1:0] scan_wide;
	logic [4+AW-1:0]    fin_wide;

	assign accept = req_valid && state_q == S_IDLE;
	assign req_stall = state_q != S_IDLE;
	assign cfg_ready = state_q == S_IDLE;
	assign rsp_valid = out_v_q;
	assign rsp = out_q;

	// the end-of-scan position may wrap, but nothing is written there
	assign scan_wide = {{AW{1'b0}}, i_q};
	assign scan_idx  = scan_wide[AW-1:0];
	assign fin_wide  = {{AW{1'b0}}, req.slot};
	assign fin_idx   = fin_wide[AW-1:0];
	assign fin_ok    = 32'(req.slot) < 32'(Slots);

	assign n       = (32'(active_q) < 32'(Slots)) ? active_q : CntW'(Slots);
	assign at_end  = i_q >= n;
	assign usable  = i_q[4] ? 1'b1 : !mask_q[i_q[3:0]];
	assign free_ok = st == SL_FREE && usable;

	// id zero is skipped after wrap
	always_comb begin
		sub_id   = next_id_q;
		sub_next = next_id_q + 1'b1;
		if (next_id_q == '0) begin
			sub_id   = sub_next;
			sub_next = sub_next + 1'b1;
		end
	end

	always_comb begin
		cmd = '0;
		idx = scan_idx;
		unique case (state_q)
			S_IDLE: begin
				if (accept && req.operation == OP_FINISH && fin_ok) begin
					cmd.finish = 1'b1;
					idx = fin_idx;
				end
			end
			S_SCAN: begin
				if (!at_end) begin
					case (op_q)
						OP_SUBMIT: begin
							if (free_ok) begin
								cmd.st_we  = 1'b1;
								cmd.st_val = SL_SUBMITTED;
								cmd.id_we  = 1'b1;
							end
						end
						OP_REAP: begin
							if (32'(k_q) < MaxReap && st == SL_DONE) begin
								cmd.st_we  = 1'b1;
								cmd.st_val = SL_FREE;
								cmd.rd_en  = 1'b1;
							end
						end
						OP_QUERY: cmd.rd_en = 1'b1;
						default: ;
					endcase
				end
			end
			S_CMP, S_RDATA, S_PUT: ;
			default: ;
		endcase
	end

	tsd_slot_table #(
		.Slots(Slots)
	) u_table (
		.clk   (clk),
		.arst_n(arst_n),
		.idx   (idx),
		.cmd   (cmd),
		.wdata (id_q),
		.st    (st),
		.rdata (rdata)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ret_q     <= S_IDLE;
			op_q      <= OP_SUBMIT;
			i_q       <= '0;
			k_q       <= '0;
			cnt_q     <= '0;
			held_v_q  <= 1'b0;
			out_v_q   <= 1'b0;
			next_id_q <= IdW'(1);
			active_q  <= '0;
			inline_q  <= 1'b1;
			mask_q    <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_ACTIVE: active_q <= cfg_data[CntW-1:0];
					CFG_INLINE: inline_q <= cfg_data[0];
					CFG_MASK:   mask_q   <= cfg_data;
					default: ;
				endcase
			end
			if (state_q == S_PUT && (!out_v_q || !rsp_stall)) begin
				out_v_q <= 1'b1;
			end else if (out_v_q && !rsp_stall) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q  <= req.operation;
						i_q   <= '0;
						k_q   <= '0;
						cnt_q <= '0;
						ret_q <= S_IDLE;
						held_v_q <= 1'b0;
						case (req.operation)
							OP_SUBMIT: begin
								next_id_q <= sub_next;
								state_q   <= inline_q ? S_PUT : S_SCAN;
							end
							OP_REAP, OP_COUNT: state_q <= inline_q ? S_PUT : S_SCAN;
							OP_QUERY: begin
								state_q <= (inline_q || req.query_id == '0) ? S_PUT : S_SCAN;
							end
							default: ;
						endcase
					end
				end
				S_SCAN: begin
					case (op_q)
						OP_SUBMIT: begin
							if (at_end || free_ok) begin
								state_q <= S_PUT;
							end else begin
								i_q <= i_q + 1'b1;
							end
						end
						OP_COUNT: begin
							if (at_end) begin
								state_q <= S_PUT;
							end else begin
								if (free_ok) begin
									cnt_q <= cnt_q + 1'b1;
								end
								i_q <= i_q + 1'b1;
							end
						end
						OP_QUERY: state_q <= at_end ? S_PUT : S_CMP;
						OP_REAP: begin
							if (at_end || 32'(k_q) >= MaxReap) begin
								held_v_q <= 1'b0;
								ret_q    <= S_IDLE;
								state_q  <= S_PUT;
							end else if (st == SL_DONE) begin
								state_q <= S_RDATA;
							end else begin
								i_q <= i_q + 1'b1;
							end
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_CMP: begin
					if (rdata == qid_q) begin
						state_q <= S_PUT;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_SCAN;
					end
				end
				S_RDATA: begin
					// previous reaped slot goes out now; this one is held
					// until we know whether it is the last
					held_v_q <= 1'b1;
					i_q      <= i_q + 1'b1;
					k_q      <= k_q + 1'b1;
					if (held_v_q) begin
						ret_q   <= S_SCAN;
						state_q <= S_PUT;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_PUT: begin
					if (!out_v_q || !rsp_stall) begin
						state_q <= ret_q;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					qid_q <= req.query_id;
					id_q  <= sub_id;
					case (req.operation)
						OP_SUBMIT: res_q <= mk_rsp(STS_INLINE, sub_id, 4'd0, 1'b0, '0, 1'b1);
						OP_REAP:   res_q <= mk_rsp(STS_NONE, '0, 4'd0, 1'b0, '0, 1'b1);
						OP_QUERY:  res_q <= mk_rsp(STS_ANSWER, '0, 4'd0, 1'b1, '0, 1'b1);
						OP_COUNT:  res_q <= mk_rsp(STS_ANSWER, '0, 4'd0, 1'b0, '0, 1'b1);
						default: ;
					endcase
				end
			end
			S_SCAN: begin
				case (op_q)
					OP_SUBMIT: begin
						if (at_end) begin
							res_q <= mk_rsp(STS_BUSY, '0, 4'd0, 1'b0, '0, 1'b1);
						end else begin
							res_q <= mk_rsp(STS_DISPATCHED, id_q, i_q[3:0], 1'b0, '0, 1'b1);
						end
					end
					OP_COUNT: res_q <= mk_rsp(STS_ANSWER, '0, 4'd0, 1'b0, cnt_q, 1'b1);
					OP_QUERY: res_q <= mk_rsp(STS_ANSWER, '0, 4'd0, 1'b1, '0, 1'b1);
					OP_REAP: begin
						if (held_v_q) begin
							res_q <= mk_rsp(STS_REAPED, held_id_q, held_slot_q, 1'b0, '0, 1'b1);
						end else begin
							res_q <= mk_rsp(STS_NONE, '0, 4'd0, 1'b0, '0, 1'b1);
						end
					end
					default: ;
				endcase
			end
			S_CMP: res_q <= mk_rsp(STS_ANSWER, '0, 4'd0, st != SL_SUBMITTED, '0, 1'b1);
			S_RDATA: begin
				res_q       <= mk_rsp(STS_REAPED, held_id_q, held_slot_q, 1'b0, '0, 1'b0);
				held_id_q   <= rdata;
				held_slot_q <= i_q[3:0];
			end
			S_PUT: begin
				if (!out_v_q || !rsp_stall) begin
					out_q <= res_q;
				end
			end
			default: ;
		endcase
	end
endmodule

// File: hw/rtl/tsd_checker.sv
// Port-level checks for the task slot dispatcher, bound to the top level.
module tsd_checker import tsd_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_stall,
	input req_t             req,
	input logic             rsp_valid,
	input logic             rsp_stall,
	input rsp_t             rsp,
	input logic             cfg_valid,
	input logic             cfg_ready,
	input logic [1:0]       cfg_index,
	input logic [MaskW-1:0] cfg_data
);
	// a stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("result changed while stalled");

	// only reaped results may be followed by more of the same request
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != STS_REAPED |-> rsp.last)
		else $error("single result without last");

	a_busy_id: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STS_BUSY |-> rsp.task_id == '0)
		else $error("busy submit carries an id");

	a_count_only_answer: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.free_count != '0 |-> rsp.status == STS_ANSWER)
		else $error("free count on a non-answer result");

	// no new request is taken while a reap is still streaming results
	a_reap_stream: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STS_REAPED && !rsp.last |-> req_stall)
		else $error("request accepted during reap");
endmodule

bind task_slot_dispatcher tsd_checker u_tsd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.req      (req),
	.rsp_valid(rsp_valid),
	.rsp_stall(rsp_stall),
	.rsp      (rsp),
	.cfg_valid(cfg_valid),
	.cfg_ready(cfg_ready),
	.cfg_index(cfg_index),
	.cfg_data (cfg_data)
);
